FILE: rtl/core/mac_learning_bridge_table_assert.svh
// Assertion macros for the learning bridge table.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef MAC_LEARNING_BRIDGE_TABLE_ASSERT_SVH
`define MAC_LEARNING_BRIDGE_TABLE_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define MLBT_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define MLBT_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/core/mlbt_pkg.sv
// Shared types and constants for the learning bridge table.
// No dependencies.
package mlbt_pkg;

    localparam int NUM_PORTS_DEF   = 4;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int PORT_SLOTS      = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    localparam logic [15:0] MAC_TIMEOUT_RST  = 16'd300;
    localparam logic [7:0]  PORT_ALIVE_RST   = 8'd20;
    localparam logic [16:0] ENTRY_AGE_MAX    = 17'h1FFFF;
    localparam logic [7:0]  PORT_AGE_MAX     = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAC_TIMEOUT = 2'd0,
        CFG_PORT_ALIVE  = 2'd1
    } cfg_index_t;

    typedef logic [2:0]  port_id_t;
    typedef logic [7:0]  port_mask_t;
    typedef logic [47:0] mac_addr_t;

    typedef struct packed {
        logic       operation;
        port_id_t   arrival_port;
        mac_addr_t  source_address;
        mac_addr_t  destination_address;
        logic       is_ethernet;
        logic       keepalive_frame;
        logic       inbound_permit;
        port_mask_t outbound_permit_mask;
    } in_item_t;

    typedef struct packed {
        port_mask_t forward_mask;
        logic       destination_known;
        logic       learned_new;
        logic       learn_dropped;
        port_mask_t port_up_mask;
    } out_item_t;

    typedef struct packed {
        logic        valid;
        mac_addr_t   address;
        port_id_t    port;
        logic [16:0] age;
    } entry_t;

endpackage

FILE: rtl/core/mac_learning_bridge_table.sv
// Transparent learning bridge address table. One item is handled at a time. A frame takes
// one full read pass over the entry memory to find destination, source and the lowest free
// slot, with the read data registered. An address move adds a second pass that flushes the
// old port's entries and finds a slot again. Learning or refreshing adds a write state, and
// the finish state loads the output register. A tick is one read-modify-write pass over the
// memory. Every pass reads the entries one by one through the single memory read port. An
// ignored frame goes straight to the finish state without a pass. in_ready rises together
// with out_valid when the result is loaded. After reset the block clears every memory entry
// before in_ready rises; config writes are taken at any time. The output register lets the
// next transfer in while a result waits.
// Depends on mlbt_pkg, mlbt_table_mem and mac_learning_bridge_table_assert.svh.
`include "mac_learning_bridge_table_assert.svh"

module mac_learning_bridge_table #(
    parameter int NUM_PORTS   = mlbt_pkg::NUM_PORTS_DEF,
    parameter int TABLE_DEPTH = mlbt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  mlbt_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output mlbt_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [mlbt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mlbt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_DEPTH - 1);
    localparam mlbt_pkg::port_mask_t IN_USE = 8'((1 << NUM_PORTS) - 1);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_FLUSH  = 6'b001000,
        ST_WRITE  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [15:0] mac_timeout_reg;
    logic [7:0]  port_alive_reg;

    // port state
    logic [7:0] port_age_reg [mlbt_pkg::PORT_SLOTS];
    logic [mlbt_pkg::PORT_SLOTS-1:0] port_up_reg;

    // held item and scan results
    mlbt_pkg::in_item_t  item_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                rd_vld_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic                dfound_reg, sfound_reg, free_found_reg;
    mlbt_pkg::port_id_t  dport_reg, sport_reg;
    logic [IDX_W-1:0]    sidx_reg, free_idx_reg, target_reg;
    mlbt_pkg::port_mask_t fwd_reg;
    logic                newl_reg, drop_reg;

    logic                out_valid_reg;
    mlbt_pkg::out_item_t out_reg;

    // memory ports
    logic               mem_we, mem_rd_en;
    logic [IDX_W-1:0]   mem_waddr, mem_raddr;
    mlbt_pkg::entry_t   mem_wdata, rd_entry;

    mlbt_table_mem #(
        .DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_raddr),
        .rd_data (rd_entry)
    );

    logic in_xfer, scan_done, is_tick, port_ok;
    logic [16:0] age_inc;
    logic aged_out, port_dead;
    mlbt_pkg::port_mask_t others, allowed, fwd_calc;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign is_tick   = item_reg.operation;
    assign scan_done = (cnt_reg == CNT_END) && !rd_vld_reg;
    assign mem_rd_en = (state_reg == ST_SCAN || state_reg == ST_FLUSH) && (cnt_reg != CNT_END);
    assign mem_raddr = cnt_reg[IDX_W-1:0];

    assign port_ok = in_data.is_ethernet && ({1'b0, in_data.arrival_port} < 4'(NUM_PORTS));

    // tick aging of the entry coming out of memory
    assign age_inc   = (rd_entry.age < mlbt_pkg::ENTRY_AGE_MAX) ? rd_entry.age + 17'd1
                                                                : rd_entry.age;
    assign port_dead = port_age_reg[rd_entry.port] >= port_alive_reg;
    assign aged_out  = age_inc > {1'b0, mac_timeout_reg};

    // forwarding decision, taken once the lookup pass is over
    always_comb
    begin
        others  = IN_USE & ~(8'd1 << item_reg.arrival_port);
        allowed = others & port_up_reg & item_reg.outbound_permit_mask;
        if (item_reg.keepalive_frame)
        begin
            fwd_calc = others;
        end
        else if (dfound_reg)
        begin
            fwd_calc = allowed & (8'd1 << dport_reg);
        end
        else
        begin
            fwd_calc = allowed;
        end
    end

    // memory write selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = rd_idx_reg;
        mem_wdata = rd_entry;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[IDX_W-1:0];
                mem_wdata = '0;
            end
            ST_SCAN:
            begin
                if (rd_vld_reg && is_tick && rd_entry.valid)
                begin
                    mem_we        = 1'b1;
                    mem_wdata.age = age_inc;
                    if (port_dead || aged_out)
                    begin
                        mem_wdata.valid = 1'b0;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (rd_vld_reg && rd_entry.valid && rd_entry.port == sport_reg)
                begin
                    mem_we          = 1'b1;
                    mem_wdata.valid = 1'b0;
                end
            end
            ST_WRITE:
            begin
                mem_we            = 1'b1;
                mem_waddr         = target_reg;
                mem_wdata.valid   = 1'b1;
                mem_wdata.address = item_reg.source_address;
                mem_wdata.port    = item_reg.arrival_port;
                mem_wdata.age     = '0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (in_data.operation || port_ok) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    if (is_tick || item_reg.keepalive_frame || !item_reg.inbound_permit)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (sfound_reg && sport_reg != item_reg.arrival_port)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else if (sfound_reg || free_found_reg)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (scan_done)
                begin
                    state_next = free_found_reg ? ST_WRITE : ST_FINISH;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            mac_timeout_reg <= mlbt_pkg::MAC_TIMEOUT_RST;
            port_alive_reg  <= mlbt_pkg::PORT_ALIVE_RST;
            port_up_reg     <= '0;
            for (int p = 0; p < mlbt_pkg::PORT_SLOTS; p++)
            begin
                port_age_reg[p] <= '0;
            end
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            dfound_reg     <= 1'b0;
            sfound_reg     <= 1'b0;
            free_found_reg <= 1'b0;
            newl_reg       <= 1'b0;
            drop_reg       <= 1'b0;
            fwd_reg        <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= mem_rd_en;

            if (cfg_we)
            begin
                case (cfg_index)
                    mlbt_pkg::CFG_MAC_TIMEOUT: mac_timeout_reg <= cfg_data;
                    mlbt_pkg::CFG_PORT_ALIVE:  port_alive_reg  <= cfg_data[7:0];
                    default:                   ;
                endcase
            end

            // in ST_FINISH the output register is reloaded below instead
            if (out_valid_reg && out_ready && state_reg != ST_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    cnt_reg <= (cnt_reg == CNT_LAST) ? '0 : cnt_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        cnt_reg        <= '0;
                        dfound_reg     <= 1'b0;
                        sfound_reg     <= 1'b0;
                        free_found_reg <= 1'b0;
                        newl_reg       <= 1'b0;
                        drop_reg       <= 1'b0;
                        fwd_reg        <= '0;
                        if (in_data.operation)
                        begin
                            // ports age before the entries are checked
                            for (int p = 0; p < mlbt_pkg::PORT_SLOTS; p++)
                            begin
                                if (port_age_reg[p] != mlbt_pkg::PORT_AGE_MAX)
                                begin
                                    port_age_reg[p] <= port_age_reg[p] + 8'd1;
                                end
                            end
                        end
                        else if (port_ok)
                        begin
                            port_age_reg[in_data.arrival_port] <= '0;
                            port_up_reg[in_data.arrival_port]  <= 1'b1;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (mem_rd_en)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (rd_vld_reg)
                    begin
                        if (is_tick)
                        begin
                            if (rd_entry.valid && port_dead)
                            begin
                                port_up_reg[rd_entry.port] <= 1'b0;
                            end
                        end
                        else
                        begin
                            if (rd_entry.valid && !dfound_reg
                                && rd_entry.address == item_reg.destination_address)
                            begin
                                dfound_reg <= 1'b1;
                                dport_reg  <= rd_entry.port;
                            end
                            if (rd_entry.valid && !sfound_reg
                                && rd_entry.address == item_reg.source_address)
                            begin
                                sfound_reg <= 1'b1;
                                sport_reg  <= rd_entry.port;
                                sidx_reg   <= rd_idx_reg;
                            end
                            if (!rd_entry.valid && !free_found_reg)
                            begin
                                free_found_reg <= 1'b1;
                                free_idx_reg   <= rd_idx_reg;
                            end
                        end
                    end
                    if (scan_done && !is_tick)
                    begin
                        fwd_reg <= fwd_calc;
                        if (!item_reg.keepalive_frame && item_reg.inbound_permit)
                        begin
                            if (sfound_reg && sport_reg != item_reg.arrival_port)
                            begin
                                // second pass frees the old port and finds a slot again
                                cnt_reg        <= '0;
                                free_found_reg <= 1'b0;
                            end
                            else if (sfound_reg)
                            begin
                                target_reg <= sidx_reg;
                            end
                            else if (free_found_reg)
                            begin
                                target_reg <= free_idx_reg;
                                newl_reg   <= 1'b1;
                            end
                            else
                            begin
                                drop_reg <= 1'b1;
                            end
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (mem_rd_en)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (rd_vld_reg && !free_found_reg
                        && (!rd_entry.valid || rd_entry.port == sport_reg))
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= rd_idx_reg;
                    end
                    if (scan_done)
                    begin
                        if (free_found_reg)
                        begin
                            target_reg <= free_idx_reg;
                        end
                        else
                        begin
                            drop_reg <= 1'b1;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg             <= 1'b1;
                        out_reg.forward_mask      <= fwd_reg;
                        out_reg.destination_known <= dfound_reg && !is_tick;
                        out_reg.learned_new       <= newl_reg;
                        out_reg.learn_dropped     <= drop_reg;
                        out_reg.port_up_mask      <= port_up_reg & IN_USE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= mem_raddr;
        if (in_xfer)
        begin
            item_reg <= in_data;
        end
    end

    // checks
    `MLBT_ASSERT_IMPLIES(a_no_rw_clash, mem_we && mem_rd_en, mem_waddr != mem_raddr, "write hits the entry being read")
    `MLBT_ASSERT_IMPLIES(a_learn_xor_drop, out_valid_reg, !(out_reg.learned_new && out_reg.learn_dropped), "learned and dropped together")
    `MLBT_ASSERT_IMPLIES(a_fwd_in_use, out_valid_reg, (out_reg.forward_mask & ~IN_USE) == 8'd0, "forward to unused port")
    `MLBT_ASSERT_IMPLIES(a_write_only_learn, state_reg == ST_WRITE, item_reg.inbound_permit && !item_reg.keepalive_frame && !item_reg.operation, "learning write without permit")

endmodule

FILE: rtl/core/mlbt_table_mem.sv
// Entry memory: one write port, one read port, registered read data.
// Depends on mlbt_pkg.
module mlbt_table_mem #(
    parameter int DEPTH = mlbt_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     wr_addr,
    input  mlbt_pkg::entry_t     wr_data,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output mlbt_pkg::entry_t     rd_data
);

    mlbt_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: bench/mac_learning_bridge_table_test.sv
// Self-checking bench for mac_learning_bridge_table: a directed table, then random phases.
// Depends on mlbt_pkg and the RTL of the bridge table; it reads no files.
module mac_learning_bridge_table_test;

    localparam int PORTS     = mlbt_pkg::NUM_PORTS_DEF;
    localparam int DEPTH     = mlbt_pkg::TABLE_DEPTH_DEF;
    localparam int SLOTS     = mlbt_pkg::PORT_SLOTS;
    localparam int SETTLE    = 2 * DEPTH + 20;   // worst item latency plus margin
    localparam int MAX_CYCLE = 3000000;
    localparam int PHASES    = 6;
    localparam int PER_PHASE = 215;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    mlbt_pkg::in_item_t    in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    mlbt_pkg::out_item_t   out_data;
    logic                  cfg_we = 1'b0;
    logic [mlbt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mlbt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    mac_learning_bridge_table dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Bench copy of the bridge state and registers
    logic [15:0]          aging_timeout;
    logic [7:0]           alive_limit;
    logic                 tbl_valid [DEPTH];
    mlbt_pkg::mac_addr_t  tbl_addr  [DEPTH];
    mlbt_pkg::port_id_t   tbl_port  [DEPTH];
    logic [16:0]          tbl_age   [DEPTH];
    logic [7:0]           pt_age    [SLOTS];
    logic                 pt_up     [SLOTS];

    mlbt_pkg::out_item_t  pending_results [$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          ticks_sent = 0;
    int          drops_seen = 0;
    int          moves_seen = 0;
    int          learns_seen = 0;
    int          cycles = 0;
    bit          calm = 1'b0;        // phase with no idling on either side

    function automatic mlbt_pkg::port_mask_t live_ports();
        mlbt_pkg::port_mask_t m;
        m = '0;
        for (int p = 0; p < PORTS; p++)
            if (pt_up[p])
                m[p] = 1'b1;
        return m;
    endfunction

    function automatic int lookup(mlbt_pkg::mac_addr_t a);
        for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && tbl_addr[i] == a)
                return i;
        return -1;
    endfunction

    // One item in, one result out; updates the bench state.
    function automatic mlbt_pkg::out_item_t bridge_apply(mlbt_pkg::in_item_t it);
        mlbt_pkg::out_item_t  r;
        mlbt_pkg::port_mask_t others;
        mlbt_pkg::port_mask_t allowed;
        mlbt_pkg::port_id_t   old;
        int         d;
        int         s;
        r = '0;
        if (it.operation)
        begin
            ticks_sent++;
            for (int p = 0; p < SLOTS; p++)
                if (pt_age[p] < mlbt_pkg::PORT_AGE_MAX)
                    pt_age[p]++;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (!tbl_valid[i])
                    continue;
                if (tbl_age[i] < mlbt_pkg::ENTRY_AGE_MAX)
                    tbl_age[i]++;
                if (pt_age[tbl_port[i]] >= alive_limit)
                begin
                    pt_up[tbl_port[i]] = 1'b0;
                    tbl_valid[i] = 1'b0;
                end
                else if (tbl_age[i] > {1'b0, aging_timeout})
                begin
                    tbl_valid[i] = 1'b0;
                end
            end
        end
        else if (it.is_ethernet && it.arrival_port < PORTS)
        begin
            others = mlbt_pkg::port_mask_t'((1 << PORTS) - 1);
            others[it.arrival_port] = 1'b0;
            pt_age[it.arrival_port] = '0;
            pt_up[it.arrival_port] = 1'b1;
            d = lookup(it.destination_address);
            r.destination_known = (d >= 0);
            if (it.keepalive_frame)
            begin
                r.forward_mask = others;
            end
            else
            begin
                allowed = others & live_ports() & it.outbound_permit_mask;
                if (d >= 0)
                    r.forward_mask = allowed & (mlbt_pkg::port_mask_t'(1) << tbl_port[d]);
                else
                    r.forward_mask = allowed;
                if (it.inbound_permit)
                begin
                    s = lookup(it.source_address);
                    if (s >= 0 && tbl_port[s] != it.arrival_port)
                    begin
                        // address moved: flush everything on the old port
                        old = tbl_port[s];
                        for (int i = 0; i < DEPTH; i++)
                            if (tbl_valid[i] && tbl_port[i] == old)
                                tbl_valid[i] = 1'b0;
                        s = -1;
                        moves_seen++;
                    end
                    else if (s < 0)
                    begin
                        r.learned_new = 1'b1;
                    end
                    if (s < 0)
                        for (int i = 0; i < DEPTH; i++)
                            if (!tbl_valid[i])
                            begin
                                s = i;
                                break;
                            end
                    if (s >= 0)
                    begin
                        tbl_valid[s] = 1'b1;
                        tbl_addr[s] = it.source_address;
                        tbl_port[s] = it.arrival_port;
                        tbl_age[s] = '0;
                        if (r.learned_new)
                            learns_seen++;
                    end
                    else
                    begin
                        r.learned_new = 1'b0;
                        r.learn_dropped = 1'b1;
                        drops_seen++;
                    end
                end
            end
        end
        r.port_up_mask = live_ports();
        return r;
    endfunction

    function automatic mlbt_pkg::mac_addr_t any_addr();
        return mlbt_pkg::mac_addr_t'({$urandom, $urandom});
    endfunction

    function automatic mlbt_pkg::in_item_t frame(int port, mlbt_pkg::mac_addr_t src,
                                                 mlbt_pkg::mac_addr_t dst, bit keep,
                                                 bit perm, mlbt_pkg::port_mask_t omask);
        mlbt_pkg::in_item_t it;
        it = '0;
        it.arrival_port = mlbt_pkg::port_id_t'(port);
        it.source_address = src;
        it.destination_address = dst;
        it.is_ethernet = 1'b1;
        it.keepalive_frame = keep;
        it.inbound_permit = perm;
        it.outbound_permit_mask = omask;
        return it;
    endfunction

    function automatic int draw_gap();
        if (calm || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // Sender: presents one item, waits for its transfer, records the expected result.
    task automatic send_item(mlbt_pkg::in_item_t it, bit typed, mlbt_pkg::out_item_t want);
        mlbt_pkg::out_item_t predicted;
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        predicted = bridge_apply(it);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        items_sent++;
    endtask

    // Hold off until the block is idle, then load both registers one after the other.
    task automatic reconfigure(logic [15:0] tmo, logic [7:0] lim);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= mlbt_pkg::CFG_MAC_TIMEOUT;
        cfg_data <= tmo;
        @(posedge clk);
        cfg_index <= mlbt_pkg::CFG_PORT_ALIVE;
        cfg_data <= mlbt_pkg::CFG_DATA_W'(lim);
        @(posedge clk);
        cfg_we <= 1'b0;
        aging_timeout = tmo;
        alive_limit = lim;
    endtask

    // Receiver: random stalls, each transfer checked against the oldest expectation.
    initial
    begin
        mlbt_pkg::out_item_t want;
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, out_data);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.forward_mask !== want.forward_mask)
                begin
                    $display("%0t: forward_mask expected %h got %h", $time,
                             want.forward_mask, out_data.forward_mask);
                    mismatches++;
                end
                if (out_data.destination_known !== want.destination_known)
                begin
                    $display("%0t: destination_known expected %b got %b", $time,
                             want.destination_known, out_data.destination_known);
                    mismatches++;
                end
                if (out_data.learned_new !== want.learned_new)
                begin
                    $display("%0t: learned_new expected %b got %b", $time,
                             want.learned_new, out_data.learned_new);
                    mismatches++;
                end
                if (out_data.learn_dropped !== want.learn_dropped)
                begin
                    $display("%0t: learn_dropped expected %b got %b", $time,
                             want.learn_dropped, out_data.learn_dropped);
                    mismatches++;
                end
                if (out_data.port_up_mask !== want.port_up_mask)
                begin
                    $display("%0t: port_up_mask expected %h got %h", $time,
                             want.port_up_mask, out_data.port_up_mask);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLE)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("mac_learning_bridge_table_test: FAIL");
            $finish;
        end
    end

    typedef struct {
        mlbt_pkg::in_item_t  item;
        bit                  typed;
        mlbt_pkg::out_item_t want;
    } row_t;

    initial
    begin
        row_t                 rows [$];
        row_t                 rw;
        mlbt_pkg::in_item_t   it;
        mlbt_pkg::mac_addr_t  pool [$];
        mlbt_pkg::mac_addr_t  a_x;
        mlbt_pkg::mac_addr_t  a_y;
        logic [127:0]         noise;
        logic [15:0]          tmo_set  [PHASES];
        logic [7:0]           lim_set  [PHASES];
        int                   pool_set [PHASES];
        int                   tick_pct [PHASES];
        int                   roll;

        tmo_set  = '{16'd300, 16'd65535, 16'd0, 16'd7, 16'd65535, 16'd40};
        lim_set  = '{8'd20, 8'd255, 8'd1, 8'd3, 8'd255, 8'd255};
        pool_set = '{8, 100, 6, 10, 90, 12};
        tick_pct = '{10, 3, 15, 20, 2, 45};

        aging_timeout = mlbt_pkg::MAC_TIMEOUT_RST;
        alive_limit = mlbt_pkg::PORT_ALIVE_RST;
        for (int i = 0; i < DEPTH; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_addr[i] = '0;
            tbl_port[i] = '0;
            tbl_age[i] = '0;
        end
        for (int p = 0; p < SLOTS; p++)
        begin
            pt_age[p] = '0;
            pt_up[p] = 1'b0;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Typed rows read straight off the spec from reset.
        a_x = 48'h0200_0000_00A1;
        a_y = 48'h0200_0000_00B2;
        rw.typed = 1'b1;
        rw.want = '0;
        rw.item = '0;
        rw.item.operation = 1'b1;                       // tick out of reset
        rows.insert(rows.size(), rw);
        rw.item = frame(0, a_x, a_y, 1'b0, 1'b1, 8'hFF);
        rw.item.is_ethernet = 1'b0;                     // non-Ethernet, ignored
        rows.insert(rows.size(), rw);
        rw.item = frame(7, a_x, a_y, 1'b0, 1'b1, 8'hFF); // port beyond those in use
        rows.insert(rows.size(), rw);
        rw.item = frame(0, a_x, a_y, 1'b1, 1'b1, 8'h00); // keepalive floods ungated
        rw.want.forward_mask = 8'h0E;
        rw.want.port_up_mask = 8'h01;
        rows.insert(rows.size(), rw);
        rw.typed = 1'b0;
        rw.want = '0;
        rw.item = frame(0, a_x, a_y, 1'b0, 1'b1, 8'hFF); rows.insert(rows.size(), rw); // learn x
        rw.item = frame(1, a_y, a_x, 1'b0, 1'b1, 8'hFF); rows.insert(rows.size(), rw); // known
        rw.item = frame(0, a_x, a_x, 1'b0, 1'b1, 8'hFF); rows.insert(rows.size(), rw); // own port
        rw.item = frame(2, 48'hFFFF_FFFF_FFFF, 48'h0, 1'b0, 1'b1, 8'hFF);
        rows.insert(rows.size(), rw);
        rw.item = frame(3, 48'h0, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, 8'hFF);
        rows.insert(rows.size(), rw);
        rw.item = frame(3, 48'h1234_5678_9ABC, a_y, 1'b0, 1'b0, 8'hFF);
        rows.insert(rows.size(), rw);
        rw.item = frame(1, a_y, a_y, 1'b0, 1'b1, 8'hFF); rows.insert(rows.size(), rw); // refresh
        rw.item = frame(1, a_x, a_y, 1'b0, 1'b1, 8'h00); rows.insert(rows.size(), rw); // x 0->1
        rw.item = frame(2, a_y, a_x, 1'b0, 1'b1, 8'h55); rows.insert(rows.size(), rw); // y 1->2
        rw.item = frame(3, a_x, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 8'hAA);
        rows.insert(rows.size(), rw);
        rw.item = '0;
        rw.item.operation = 1'b1;
        rw.item.arrival_port = 3'd7;
        rw.item.source_address = 48'hFFFF_FFFF_FFFF;
        rw.item.destination_address = 48'hFFFF_FFFF_FFFF;
        rw.item.outbound_permit_mask = 8'hFF;
        for (int k = 0; k < 4; k++)
            rows.insert(rows.size(), rw);
        rw.item = frame(2, a_x, a_y, 1'b0, 1'b1, 8'hFF); rows.insert(rows.size(), rw);
        foreach (rows[k])
            send_item(rows[k].item, rows[k].typed, rows[k].want);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            reconfigure(tmo_set[ph], lim_set[ph]);
            calm = (ph == 3);
            pool.delete();
            for (int k = 0; k < pool_set[ph]; k++)
                pool.insert(pool.size(), any_addr());
            for (int n = 0; n < PER_PHASE; n++)
            begin
                roll = $urandom_range(0, 99);
                it = frame($urandom_range(0, PORTS - 1),
                           pool[$urandom_range(0, pool.size() - 1)],
                           pool[$urandom_range(0, pool.size() - 1)],
                           $urandom_range(0, 9) == 0, $urandom_range(0, 6) != 0,
                           $urandom_range(0, 2) == 0 ? 8'hFF
                                                     : mlbt_pkg::port_mask_t'($urandom));
                if (roll < tick_pct[ph])
                begin
                    it.operation = 1'b1;
                end
                else if (roll < tick_pct[ph] + 4)
                begin
                    // noise: fully random fields on a frame
                    noise = {$urandom, $urandom, $urandom, $urandom};
                    it = mlbt_pkg::in_item_t'(noise[$bits(mlbt_pkg::in_item_t)-1:0]);
                    it.operation = 1'b0;
                end
                else if (roll < tick_pct[ph] + 8)
                begin
                    it.destination_address = any_addr();
                end
                send_item(it, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d items (%0d ticks) over %0d register settings; %0d results.",
                 items_sent, ticks_sent, PHASES + 1, results_seen);
        $display("New learns %0d, moves %0d, full-table drops %0d, mismatches %0d.",
                 learns_seen, moves_seen, drops_seen, mismatches);
        if (mismatches == 0)
            $display("mac_learning_bridge_table_test: PASS");
        else
            $display("mac_learning_bridge_table_test: FAIL");
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/mlbt_pkg.sv
rtl/core/mlbt_table_mem.sv
rtl/core/mac_learning_bridge_table.sv
bench/mac_learning_bridge_table_test.sv
